/* src/hbfc_pkg.sv */
// types and constants shared by the format converter
package hbfc_pkg;

	typedef enum logic [1:0] {
		CMD_F32_TO_F16  = 2'd0,
		CMD_F16_TO_F32  = 2'd1,
		CMD_F32_TO_BF16 = 2'd2,
		CMD_BF16_TO_F32 = 2'd3
	} cmd_t;

	localparam logic [15:0] F16_INF      = 16'h7C00;
	localparam logic [15:0] F16_QUIET    = 16'h0200;
	localparam logic [23:0] F16_HALF_ULP = 24'h001000;
	localparam logic [23:0] F32_HIDDEN   = 24'h800000;
	localparam logic [31:0] BF16_BIAS    = 32'h0000_7FFF;
	localparam logic [15:0] BF16_QUIET   = 16'h0040;
	localparam logic [31:0] F32_INF      = 32'h7F80_0000;
	localparam logic [9:0]  F16_MANT     = 10'h3FF;

	localparam logic [7:0]  F32_EXP_ALL1  = 8'hFF;
	localparam logic [7:0]  F32_F16_BIAS  = 8'd112;
	localparam logic [7:0]  F16_OVF_EXP   = 8'd143;
	localparam logic [7:0]  F16_TINY_EXP  = 8'd102;
	localparam logic [7:0]  F16_SUB_SHIFT = 8'd126;
	localparam logic [7:0]  F16_SUB_EXP   = 8'd113;
	localparam logic [4:0]  F16_EXP_ALL1  = 5'h1F;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] operand;
		logic        f32_nan;
		logic        f32_infnan;
		logic        f32_ovf;
		logic        f32_tiny;
		logic        f32_sub;
		logic [4:0]  sub_shift;
		logic [3:0]  lead_shift;
	} stage1_t;

	typedef struct packed {
		cmd_t        cmd;
		logic        done;
		logic [31:0] res;
		logic        sign;
		logic [10:0] rmant;
		logic [4:0]  rexp;
	} stage2_t;

endpackage

/* src/hbfc_if.sv */
// request and response channel interfaces of the format converter
interface hbfc_req_if;
	logic               valid;
	logic               ready;
	hbfc_pkg::cmd_t     command;
	logic [31:0]        operand;

	modport source (output valid, output command, output operand, input ready);
	modport sink (input valid, input command, input operand, output ready);
endinterface

interface hbfc_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);
endinterface

/* src/half_and_bfloat16_format_converter.sv */
// converter between binary32 and binary16 / bfloat16 bit patterns
//
// request channel carries a command and a 32-bit operand; 16-bit sources sit
// in the low half. response channel returns one 32-bit result per
// transaction, 16-bit results zero-extended.
// three register stages: decode and classify, rounding add / renormalising
// shift, result assembly into the output register.
// a request accepted by the decode stage passes through the rounding stage
// and leaves from the output register as a response.
// throughput is one transaction per cycle while the response side takes
// results; the rounding adder of the second stage sets the cycle depth.
// when the response side stalls, each stage holds its transaction and the
// request ready falls only once all three stages are full; nothing is lost
// or repeated, and the stalled result stays on the port.
// reset clears the stage valid flags; the block can take a request as soon
// as reset is released.
module half_and_bfloat16_format_converter (
	input  logic        clk,
	input  logic        arst_n,
	hbfc_req_if.sink    request,
	hbfc_rsp_if.source  response
);
	import hbfc_pkg::*;

	logic        v_s1, v_s2, v_s3;
	logic        adv1, adv2, adv3;
	stage1_t     d_s1, nxt_s1;
	stage2_t     d_s2, nxt_s2;
	cmd_t        cmd_s3;
	logic [31:0] result_s3, nxt_s3;

	assign adv3 = !v_s3 || response.ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign request.ready = adv1;
	assign response.valid = v_s3;
	assign response.result = result_s3;

	// decode and classify
	always_comb begin
		logic [7:0] ef;
		logic [22:0] mant;
		ef = request.operand[30:23];
		mant = request.operand[22:0];
		nxt_s1.cmd = request.command;
		nxt_s1.operand = request.operand;
		nxt_s1.f32_infnan = (ef == F32_EXP_ALL1);
		nxt_s1.f32_nan = (ef == F32_EXP_ALL1) && (mant != 23'd0);
		nxt_s1.f32_ovf = (ef >= F16_OVF_EXP);
		nxt_s1.f32_tiny = (ef < F16_TINY_EXP);
		nxt_s1.f32_sub = (ef <= F32_F16_BIAS);
		nxt_s1.sub_shift = 5'(F16_SUB_SHIFT - ef);
		nxt_s1.lead_shift = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (request.operand[i]) begin
				nxt_s1.lead_shift = 4'(10 - i);
			end
		end
	end

	// rounding and renormalising; results that need no carry fix are completed here
	always_comb begin
		logic        sign16;
		logic [7:0]  ef;
		logic [22:0] mant;
		logic [24:0] sub_sum;
		logic [24:0] sub_rnd;
		logic [23:0] nrm_sum;
		logic [4:0]  he;
		logic [9:0]  hm;
		logic [10:0] hm_sh;
		logic [31:0] bf_sum;
		sign16 = d_s1.operand[31];
		ef = d_s1.operand[30:23];
		mant = d_s1.operand[22:0];
		sub_sum = {1'b0, F32_HIDDEN | {1'b0, mant}} + (25'd1 << (d_s1.sub_shift - 5'd1));
		sub_rnd = sub_sum >> d_s1.sub_shift;
		nrm_sum = {1'b0, mant} + F16_HALF_ULP - 24'd1 + {23'd0, mant[13]};
		he = d_s1.operand[14:10];
		hm = d_s1.operand[9:0];
		hm_sh = {1'b0, hm} << d_s1.lead_shift;
		bf_sum = d_s1.operand + BF16_BIAS + {31'd0, d_s1.operand[16]};
		nxt_s2.cmd = d_s1.cmd;
		nxt_s2.done = 1'b1;
		nxt_s2.res = 32'd0;
		nxt_s2.sign = sign16;
		nxt_s2.rmant = 11'd0;
		nxt_s2.rexp = 5'd0;
		unique case (d_s1.cmd)
			CMD_F32_TO_F16: begin
				if (d_s1.f32_infnan) begin
					nxt_s2.res = {16'd0, ({sign16, 15'd0} | F16_INF |
						(d_s1.f32_nan ? F16_QUIET : 16'd0))};
				end else if (d_s1.f32_ovf) begin
					nxt_s2.res = {16'd0, ({sign16, 15'd0} | F16_INF)};
				end else if (d_s1.f32_tiny) begin
					nxt_s2.res = {16'd0, sign16, 15'd0};
				end else if (d_s1.f32_sub) begin
					nxt_s2.done = 1'b0;
					nxt_s2.rmant = sub_rnd[10:0];
				end else begin
					nxt_s2.done = 1'b0;
					nxt_s2.rmant = nrm_sum[23:13];
					nxt_s2.rexp = 5'(ef - F32_F16_BIAS);
				end
			end
			CMD_F16_TO_F32: begin
				if (he == 5'd0) begin
					if (hm == 10'd0) begin
						nxt_s2.res = {d_s1.operand[15], 31'd0};
					end else begin
						nxt_s2.res = {d_s1.operand[15],
							8'(F16_SUB_EXP - {4'd0, d_s1.lead_shift}),
							hm_sh[9:0] & F16_MANT, 13'd0};
					end
				end else if (he == F16_EXP_ALL1) begin
					nxt_s2.res = {d_s1.operand[15], 31'd0} | F32_INF | {9'd0, hm, 13'd0};
				end else begin
					nxt_s2.res = {d_s1.operand[15], 8'({3'd0, he} + F32_F16_BIAS),
						hm, 13'd0};
				end
			end
			CMD_F32_TO_BF16: begin
				if (d_s1.f32_nan) begin
					nxt_s2.res = {16'd0, (d_s1.operand[31:16] | BF16_QUIET)};
				end else begin
					nxt_s2.res = {16'd0, bf_sum[31:16]};
				end
			end
			CMD_BF16_TO_F32: begin
				nxt_s2.res = {d_s1.operand[15:0], 16'd0};
			end
			default: begin
				nxt_s2.res = 32'd0;
			end
		endcase
	end

	// assembly with mantissa carry
	always_comb begin
		logic [5:0] re6;
		logic [9:0] m;
		if (d_s2.rmant[10]) begin
			re6 = {1'b0, d_s2.rexp} + 6'd1;
			m = 10'd0;
		end else begin
			re6 = {1'b0, d_s2.rexp};
			m = d_s2.rmant[9:0];
		end
		if (d_s2.done) begin
			nxt_s3 = d_s2.res;
		end else if (re6 >= {1'b0, F16_EXP_ALL1}) begin
			nxt_s3 = {16'd0, ({d_s2.sign, 15'd0} | F16_INF)};
		end else begin
			nxt_s3 = {16'd0, d_s2.sign, re6[4:0], m};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= request.valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && request.valid) begin
			d_s1 <= nxt_s1;
		end
		if (adv2 && v_s1) begin
			d_s2 <= nxt_s2;
		end
		if (adv3 && v_s2) begin
			result_s3 <= nxt_s3;
			cmd_s3 <= d_s2.cmd;
		end
	end

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!request.ready |-> (v_s1 && v_s2 && v_s3))
		else $error("request blocked while a stage is free");

	a_narrow_result: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && (cmd_s3 == CMD_F32_TO_F16 || cmd_s3 == CMD_F32_TO_BF16)
		|-> result_s3[31:16] == 16'd0)
		else $error("16-bit result not zero-extended");

	a_bf16_widen: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && cmd_s3 == CMD_BF16_TO_F32 |-> result_s3[15:0] == 16'd0)
		else $error("bfloat16 widening left low bits set");

	a_f16_quiet_nan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && cmd_s3 == CMD_F32_TO_F16 && result_s3[14:10] == F16_EXP_ALL1
		&& result_s3[9:0] != 10'd0 |-> result_s3[9:0] == F16_QUIET[9:0])
		else $error("half NaN not the canonical quiet pattern");

endmodule
